// ===== hw/rtl/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

	localparam int HCBD_COUNT_WIDTH = 32;
	localparam int BYTE_W           = 8;
	localparam int STATUS_W         = 2;
	localparam int PDATA_W          = 32;
	localparam int PADDR_W          = 3;

	localparam logic [BYTE_W-1:0]  CHAR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0]  CHAR_LF = 8'h0A;
	localparam logic [PDATA_W-1:0] LIMIT_RESET = 32'h0010_0000;

	// register index taken from paddr[PADDR_W-1:2]
	localparam logic [PADDR_W-3:0] REG_BODY_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		PH_SIZE   = 2'd0,
		PH_DATA   = 2'd1,
		PH_TRAIL1 = 2'd2,
		PH_TRAIL2 = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		NS_WS     = 3'd0,
		NS_SIGNED = 3'd1,
		NS_ZERO   = 3'd2,
		NS_PREFIX = 3'd3,
		NS_DIGITS = 3'd4,
		NS_STOP   = 3'd5
	} num_stage_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_RUNNING    = 2'd0,
		ST_LAST_CHUNK = 2'd1,
		ST_OVER_LIMIT = 2'd2,
		ST_CLOSED     = 2'd3
	} stop_t;

	typedef struct packed {
		phase_t     phase;
		num_stage_t stage;
		logic       saw_cr;
		logic       is_neg;
		stop_t      stop;
	} ctrl_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   data_byte;
		logic                data_valid;
		logic                finished;
		logic [STATUS_W-1:0] end_status;
	} result_t;

	localparam ctrl_t CTRL_RESET = '{
		phase:  PH_SIZE,
		stage:  NS_WS,
		saw_cr: 1'b0,
		is_neg: 1'b0,
		stop:   ST_RUNNING
	};

	// {is hex, value}
	function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - "0")};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [BYTE_W-1:0] c);
		return (c == " ") || (c >= 8'd9 && c <= 8'd13);
	endfunction

endpackage

// ===== hw/rtl/hcbd_if.sv =====
`timescale 1ns / 1ps

interface hcbd_in_if import hcbd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              restart;
	logic              closed;

	modport source (output valid, in_byte, restart, closed, input ready);
	modport sink   (input valid, in_byte, restart, closed, output ready);
endinterface

interface hcbd_out_if import hcbd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   data_byte;
	logic                data_valid;
	logic                finished;
	logic [STATUS_W-1:0] end_status;

	modport source (output valid, data_byte, data_valid, finished, end_status, input ready);
	modport sink   (input valid, data_byte, data_valid, finished, end_status, output ready);
endinterface

// ===== hw/rtl/hcbd_cfg.sv =====
`timescale 1ns / 1ps

module hcbd_cfg import hcbd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [PDATA_W-1:0] body_limit
);

	logic [PDATA_W-1:0] limit_q;
	logic               hit_limit;

	assign pready    = 1'b1;
	assign hit_limit = (paddr[PADDR_W-1:2] == REG_BODY_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && hit_limit) begin
			limit_q <= pwdata;
		end
	end

	assign prdata     = hit_limit ? limit_q : '0;
	assign body_limit = limit_q;

endmodule

// ===== hw/rtl/hcbd_step.sv =====
`timescale 1ns / 1ps

module hcbd_step import hcbd_pkg::*; #(
	parameter int COUNT_WIDTH = HCBD_COUNT_WIDTH
) (
	input  ctrl_t                   ctrl,
	input  logic [COUNT_WIDTH-1:0]  size_accum,
	input  logic [COUNT_WIDTH-1:0]  bytes_left,
	input  logic [COUNT_WIDTH-1:0]  total_out,
	input  logic [BYTE_W-1:0]       in_byte,
	input  logic                    restart,
	input  logic                    closed,
	input  logic [PDATA_W-1:0]      body_limit,
	output ctrl_t                   ctrl_nxt,
	output logic [COUNT_WIDTH-1:0]  size_accum_nxt,
	output logic [COUNT_WIDTH-1:0]  bytes_left_nxt,
	output logic [COUNT_WIDTH-1:0]  total_out_nxt,
	output result_t                 result
);

	localparam int SUM_W = ((COUNT_WIDTH > PDATA_W) ? COUNT_WIDTH : PDATA_W) + 1;

	ctrl_t                  cur;
	logic [COUNT_WIDTH-1:0] acc_cur, left_cur, total_cur;
	// line state the size byte works on
	num_stage_t             l_stage;
	logic                   l_cr, l_neg;
	logic [COUNT_WIDTH-1:0] l_acc;
	logic                   do_size, out_valid;
	logic [4:0]             hex;
	logic [COUNT_WIDTH-1:0] acc_dig;
	logic [SUM_W-1:0]       sum;
	logic [COUNT_WIDTH-1:0] left_dec;

	always_comb begin
		cur       = restart ? CTRL_RESET : ctrl;
		acc_cur   = restart ? '0 : size_accum;
		left_cur  = restart ? '0 : bytes_left;
		total_cur = restart ? '0 : total_out;

		ctrl_nxt       = cur;
		size_accum_nxt = acc_cur;
		bytes_left_nxt = left_cur;
		total_out_nxt  = total_cur;
		out_valid      = 1'b0;
		do_size        = 1'b0;
		l_stage        = cur.stage;
		l_cr           = cur.saw_cr;
		l_neg          = cur.is_neg;
		l_acc          = acc_cur;
		left_dec       = left_cur - 1'b1;

		hex = hex_digit(in_byte);
		// shift in one digit, saturating
		if (l_acc[COUNT_WIDTH-1 -: 4] != 4'd0) begin
			acc_dig = '1;
		end else begin
			acc_dig = {l_acc[COUNT_WIDTH-5:0], hex[3:0]};
		end
		sum = SUM_W'(total_cur) + SUM_W'(l_acc);

		if (cur.stop == ST_RUNNING) begin
			if (closed) begin
				ctrl_nxt.stop = ST_CLOSED;
			end else begin
				unique case (cur.phase)
					PH_SIZE: begin
						do_size = 1'b1;
					end
					PH_DATA: begin
						out_valid      = 1'b1;
						bytes_left_nxt = left_dec;
						if (left_dec == '0) begin
							ctrl_nxt.phase = PH_TRAIL1;
						end
					end
					PH_TRAIL1: begin
						if (in_byte == CHAR_CR) begin
							ctrl_nxt.phase = PH_TRAIL2;
						end else begin
							ctrl_nxt.phase = PH_SIZE;
							do_size        = 1'b1;
						end
					end
					PH_TRAIL2: begin
						// a lone CR and a fresh line parse the next byte alike
						ctrl_nxt.phase = PH_SIZE;
						do_size        = (in_byte != CHAR_LF);
					end
				endcase
				if (cur.phase != PH_SIZE && cur.phase != PH_DATA) begin
					l_stage = NS_WS;
					l_cr    = 1'b0;
					l_neg   = 1'b0;
					l_acc   = '0;
					acc_dig = {{(COUNT_WIDTH-4){1'b0}}, hex[3:0]};
					sum     = SUM_W'(total_cur);
				end
			end
		end

		ctrl_nxt.stage  = l_stage;
		ctrl_nxt.saw_cr = l_cr;
		ctrl_nxt.is_neg = l_neg;
		size_accum_nxt  = l_acc;

		if (do_size) begin
			if (l_cr && in_byte == CHAR_LF) begin
				// line end: settle the chunk size
				if (l_neg || l_acc == '0) begin
					ctrl_nxt.stop = ST_LAST_CHUNK;
				end else if (sum > SUM_W'(body_limit)) begin
					ctrl_nxt.stop = ST_OVER_LIMIT;
				end else begin
					total_out_nxt  = sum[COUNT_WIDTH-1:0];
					bytes_left_nxt = l_acc;
					ctrl_nxt.phase = PH_DATA;
				end
				ctrl_nxt.stage  = NS_WS;
				ctrl_nxt.saw_cr = 1'b0;
				ctrl_nxt.is_neg = 1'b0;
				size_accum_nxt  = '0;
			end else begin
				ctrl_nxt.saw_cr = (in_byte == CHAR_CR);
				unique case (l_stage)
					NS_WS: begin
						if (is_space(in_byte)) begin
							ctrl_nxt.stage = NS_WS;
						end else if (in_byte == "+" || in_byte == "-") begin
							ctrl_nxt.is_neg = (in_byte == "-");
							ctrl_nxt.stage  = NS_SIGNED;
						end else if (in_byte == "0") begin
							ctrl_nxt.stage = NS_ZERO;
						end else if (hex[4]) begin
							size_accum_nxt = acc_dig;
							ctrl_nxt.stage = NS_DIGITS;
						end else begin
							ctrl_nxt.stage = NS_STOP;
						end
					end
					NS_SIGNED: begin
						if (in_byte == "0") begin
							ctrl_nxt.stage = NS_ZERO;
						end else if (hex[4]) begin
							size_accum_nxt = acc_dig;
							ctrl_nxt.stage = NS_DIGITS;
						end else begin
							ctrl_nxt.stage = NS_STOP;
						end
					end
					NS_ZERO: begin
						if (in_byte == "x" || in_byte == "X") begin
							ctrl_nxt.stage = NS_PREFIX;
						end else if (hex[4]) begin
							size_accum_nxt = acc_dig;
							ctrl_nxt.stage = NS_DIGITS;
						end else begin
							ctrl_nxt.stage = NS_STOP;
						end
					end
					NS_PREFIX, NS_DIGITS: begin
						if (hex[4]) begin
							size_accum_nxt = acc_dig;
							ctrl_nxt.stage = NS_DIGITS;
						end else begin
							ctrl_nxt.stage = NS_STOP;
						end
					end
					default: begin
						ctrl_nxt.stage = l_stage;
					end
				endcase
			end
		end

		result.data_byte  = out_valid ? in_byte : '0;
		result.data_valid = out_valid;
		result.finished   = (ctrl_nxt.stop != ST_RUNNING);
		result.end_status = ctrl_nxt.stop;
	end

endmodule

// ===== hw/rtl/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps
// An accepted beat is held in the input register, then takes one pass of the
// step logic into the output register, from which the result beat can leave.
// Throughput: one beat per cycle while the receiver takes results; a stalled
// receiver holds the flow. The rate is set by the state update loop.
// Reset: arst_n clears pipeline valids, decoder state and sets the body limit
// to 1048576; no clearing pass, the block is ready straight after reset.
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int COUNT_WIDTH = HCBD_COUNT_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	hcbd_in_if.sink            raw,
	hcbd_out_if.source         body,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// Input register: holds one raw beat until the step logic can take it.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              restart_s1;
	logic              closed_s1;

	// Decoder state.
	ctrl_t                  ctrl_q;
	logic [COUNT_WIDTH-1:0] size_accum_q;
	logic [COUNT_WIDTH-1:0] bytes_left_q;
	logic [COUNT_WIDTH-1:0] total_out_q;

	// Result register.
	logic    out_valid_q;
	result_t result_q;

	ctrl_t                  ctrl_nxt;
	logic [COUNT_WIDTH-1:0] size_accum_nxt;
	logic [COUNT_WIDTH-1:0] bytes_left_nxt;
	logic [COUNT_WIDTH-1:0] total_out_nxt;
	result_t                result_nxt;
	logic [PDATA_W-1:0]     body_limit;
	logic                   advance;

	hcbd_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.body_limit (body_limit)
	);

	hcbd_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.ctrl           (ctrl_q),
		.size_accum     (size_accum_q),
		.bytes_left     (bytes_left_q),
		.total_out      (total_out_q),
		.in_byte        (byte_s1),
		.restart        (restart_s1),
		.closed         (closed_s1),
		.body_limit     (body_limit),
		.ctrl_nxt       (ctrl_nxt),
		.size_accum_nxt (size_accum_nxt),
		.bytes_left_nxt (bytes_left_nxt),
		.total_out_nxt  (total_out_nxt),
		.result         (result_nxt)
	);

	// Advance the held beat when the result register is empty or being drained;
	// the input register refills in the same cycle, so a stalled result costs
	// nothing until both registers are full.
	assign advance   = valid_s1 && (!out_valid_q || body.ready);
	assign raw.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1    <= raw.in_byte;
			restart_s1 <= raw.restart;
			closed_s1  <= raw.closed;
		end
	end

	// Commit the state update only for a beat that moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       <= CTRL_RESET;
			size_accum_q <= '0;
			bytes_left_q <= '0;
			total_out_q  <= '0;
		end else if (advance) begin
			ctrl_q       <= ctrl_nxt;
			size_accum_q <= size_accum_nxt;
			bytes_left_q <= bytes_left_nxt;
			total_out_q  <= total_out_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (body.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign body.valid      = out_valid_q;
	assign body.data_byte  = result_q.data_byte;
	assign body.data_valid = result_q.data_valid;
	assign body.finished   = result_q.finished;
	assign body.end_status = result_q.end_status;

	// A data beat is only ever produced while decoding is still running.
	a_data_not_finished: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.data_valid |-> !result_q.finished)
		else $error("data beat flagged as finished");

	// Finished and a non-running status go together.
	a_finished_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.finished == (result_q.end_status != ST_RUNNING)))
		else $error("finished flag disagrees with end status");

	// In the data phase at least one byte of the chunk is still owed.
	a_data_phase_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.phase == PH_DATA |-> bytes_left_q != '0)
		else $error("data phase with no bytes left");

	// A committed chunk total stays within the limit in force when it was set.
	a_total_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctrl_q.phase == PH_SIZE && ctrl_nxt.phase == PH_DATA
		|-> ({1'b0, total_out_nxt} <= {1'b0, COUNT_WIDTH'(body_limit)}) ||
			(COUNT_WIDTH < PDATA_W))
		else $error("chunk accepted past the body limit");

endmodule

// ===== tb/tb_http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
	import hcbd_pkg::*;

	localparam int CW          = HCBD_COUNT_WIDTH;
	localparam int IDLE_PCT    = 21;
	localparam int HOLD_CYCLES = 120;
	// No beat moves for this many cycles: the block is hung.
	localparam int QUIET_LIMIT = 2000;

	localparam logic [CW-1:0] COUNT_MAX = '1;

	// One raw beat as the sender offers it.
	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              restart;
		logic              closed;
	} raw_beat_t;

	// Tracks the decoder state beat by beat and holds the body beats still owed.
	class body_decode_check;
		phase_t             ph;
		num_stage_t         stage;
		bit                 saw_cr;
		bit                 neg;
		logic [CW-1:0]      accum;
		logic [CW-1:0]      left;
		logic [CW-1:0]      total;
		logic [PDATA_W-1:0] limit;
		stop_t              stop;
		result_t            expected_body[$];
		int                 errors;
		int                 n_beats;

		function new();
			limit = LIMIT_RESET;
			errors = 0;
			n_beats = 0;
			restart_body();
		endfunction

		function void set_limit(input logic [PDATA_W-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return expected_body.size();
		endfunction

		function void clear_line();
			stage = NS_WS;
			saw_cr = 1'b0;
			neg = 1'b0;
			accum = '0;
		endfunction

		function void restart_body();
			ph = PH_SIZE;
			clear_line();
			left = '0;
			total = '0;
			stop = ST_RUNNING;
		endfunction

		// Saturate once another digit would push the size past the counter.
		function void add_digit(input logic [3:0] d);
			if (accum > (COUNT_MAX >> 4)) begin
				accum = COUNT_MAX;
			end else begin
				accum = {accum[CW-5:0], d};
			end
			stage = NS_DIGITS;
		endfunction

		function void parse_char(input logic [BYTE_W-1:0] c);
			bit         is_hex;
			logic [3:0] v;
			is_hex = 1'b1;
			v = 4'd0;
			if (c >= "0" && c <= "9") begin
				v = c[3:0];
			end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
				v = c[3:0] + 4'd9;
			end else begin
				is_hex = 1'b0;
			end
			if (stage == NS_WS) begin
				if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
					return;
				end
				if (c == "+" || c == "-") begin
					neg = (c == "-");
					stage = NS_SIGNED;
					return;
				end
			end
			case (stage)
				NS_WS, NS_SIGNED: begin
					if (c == "0") stage = NS_ZERO;
					else if (is_hex) add_digit(v);
					else stage = NS_STOP;
				end
				NS_ZERO: begin
					if (c == "x" || c == "X") stage = NS_PREFIX;
					else if (is_hex) add_digit(v);
					else stage = NS_STOP;
				end
				NS_PREFIX, NS_DIGITS: begin
					if (is_hex) add_digit(v);
					else stage = NS_STOP;
				end
				default: ;
			endcase
		endfunction

		function void end_line();
			logic [CW:0] sum;
			sum = {1'b0, total} + {1'b0, accum};
			if (neg || accum == '0) begin
				stop = ST_LAST_CHUNK;
			end else if (sum > (CW+1)'(limit)) begin
				stop = ST_OVER_LIMIT;
			end else begin
				total = sum[CW-1:0];
				left = accum;
				ph = PH_DATA;
			end
			clear_line();
		endfunction

		function void size_byte(input logic [BYTE_W-1:0] c);
			if (saw_cr && c == CHAR_LF) begin
				end_line();
				return;
			end
			parse_char(c);
			saw_cr = (c == CHAR_CR);
		endfunction

		function void note_raw(input raw_beat_t b);
			result_t r;
			bit      valid;
			valid = 1'b0;
			if (b.restart) begin
				restart_body();
			end
			if (stop == ST_RUNNING) begin
				if (b.closed) begin
					stop = ST_CLOSED;
				end else begin
					case (ph)
						PH_SIZE: size_byte(b.ch);
						PH_DATA: begin
							valid = 1'b1;
							left = left - 1;
							if (left == '0) ph = PH_TRAIL1;
						end
						PH_TRAIL1: begin
							if (b.ch == CHAR_CR) begin
								ph = PH_TRAIL2;
							end else begin
								ph = PH_SIZE;
								clear_line();
								size_byte(b.ch);
							end
						end
						default: begin
							ph = PH_SIZE;
							clear_line();
							if (b.ch != CHAR_LF) begin
								saw_cr = 1'b1;
								size_byte(b.ch);
							end
						end
					endcase
				end
			end
			r.data_byte  = valid ? b.ch : 8'h00;
			r.data_valid = valid;
			r.finished   = (stop != ST_RUNNING);
			r.end_status = stop;
			expected_body.insert(expected_body.size(), r);
		endfunction

		task report(input string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_body(input result_t got);
			result_t want;
			string   bad;
			n_beats++;
			if (expected_body.size() == 0) begin
				report($sformatf("body beat %0d arrived with nothing outstanding", n_beats));
				return;
			end
			want = expected_body.pop_front();
			bad = "";
			if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
			if (got.data_valid !== want.data_valid) bad = {bad, " data_valid"};
			if (got.finished !== want.finished) bad = {bad, " finished"};
			if (got.end_status !== want.end_status) bad = {bad, " end_status"};
			if (bad != "") begin
				report($sformatf("body beat %0d wrong%s: got %h/%b/%b/%0d want %h/%b/%b/%0d",
					n_beats, bad, got.data_byte, got.data_valid, got.finished,
					got.end_status, want.data_byte, want.data_valid, want.finished,
					want.end_status));
			end
		endtask

		task close_out();
			if (expected_body.size() != 0) begin
				report($sformatf("%0d body beats never arrived", expected_body.size()));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	hcbd_in_if  raw_if ();
	hcbd_out_if body_if ();

	raw_beat_t        raw_q[$];
	bit               idle_on = 1'b1;
	bit               hold_req = 1'b0;
	int               quiet_cycles = 0;
	body_decode_check decode_chk = new();

	http_chunked_body_decoder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_if),
		.body    (body_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Note each accepted raw beat before looking at the body side, so the
	// expectation is in place even if a body beat were to follow at once.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (raw_if.valid === 1'b1 && raw_if.ready === 1'b1) begin
				decode_chk.note_raw(raw_beat_t'({raw_if.in_byte, raw_if.restart,
					raw_if.closed}));
			end
			if (body_if.valid === 1'b1 && body_if.ready === 1'b1) begin
				decode_chk.check_body(result_t'({body_if.data_byte, body_if.data_valid,
					body_if.finished, body_if.end_status}));
			end
		end
	end

	// Watchdog: give up once neither side has moved a beat for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (raw_if.valid === 1'b1 && raw_if.ready === 1'b1) ||
				(body_if.valid === 1'b1 && body_if.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: stall at random, or hold off for a long stretch on request
	// so that the block backs up and drops its own ready.
	initial begin
		body_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				body_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				body_if.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	function automatic void put(input logic [BYTE_W-1:0] c, input bit rs = 1'b0,
			input bit cl = 1'b0);
		raw_beat_t b;
		b.ch = c;
		b.restart = rs;
		b.closed = cl;
		raw_q.insert(raw_q.size(), b);
	endfunction

	function automatic void put_text(input string s);
		foreach (s[i]) put(s[i]);
	endfunction

	// Write a size line in one of the spellings a base-16 strtol accepts,
	// sometimes with a chunk extension or junk after the digits.
	function automatic void put_size_line(input int size);
		string digits;
		digits = $sformatf("%0h", size);
		if ($urandom_range(0, 1) == 1) digits = digits.toupper();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) put(($urandom_range(0, 1) == 1) ? 8'h20 : 8'h09);
		end
		case ($urandom_range(0, 9))
			0: put("+");
			1: put_text("0x");
			2: put_text("0X");
			3: put("0");
			default: ;
		endcase
		put_text(digits);
		case ($urandom_range(0, 7))
			0: put_text(";name=val");
			1: put_text(" \t;");
			2: put(8'h00);
			3: put(CHAR_LF);
			default: ;
		endcase
		put(CHAR_CR);
		put(CHAR_LF);
	endfunction

	// One chunked body with random content; most are well formed, some are
	// cut short by a close, carry an oversized chunk or a damaged trailer.
	function automatic void build_body(input int widest);
		int start;
		int n_chunks;
		int size;
		int kind;
		bit cut;
		start = raw_q.size();
		n_chunks = $urandom_range(1, 4);
		cut = 1'b0;
		for (int k = 0; k < n_chunks && !cut; k++) begin
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				if ($urandom_range(0, 1) == 1) put_text("fffffffffff");
				else put_text("100000000");
				put_text("\r\n");
				repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)));
			end else if (kind == 1) begin
				size = $urandom_range(2, widest);
				put_size_line(size);
				repeat ($urandom_range(0, size - 1)) put(8'($urandom_range(0, 255)));
				put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				cut = 1'b1;
			end else begin
				if ($urandom_range(0, 7) == 0) size = $urandom_range(1, widest * 3);
				else size = $urandom_range(1, widest);
				put_size_line(size);
				repeat (size) put(8'($urandom_range(0, 255)));
				case ($urandom_range(0, 19))
					0: ;
					1: put(CHAR_CR);
					2: put(CHAR_LF);
					default: begin
						put(CHAR_CR);
						put(CHAR_LF);
					end
				endcase
			end
		end
		if (!cut) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					put_text("0\r\n");
					if ($urandom_range(0, 3) == 0) put_text("X-Tail: 1\r\n");
					put_text("\r\n");
				end
				6: begin
					put("-");
					put_text($sformatf("%0h", $urandom_range(0, 15)));
					put_text("\r\n");
				end
				7: put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				8: put_text("0x\r\n");
				default: ;
			endcase
		end
		if ($urandom_range(0, 9) != 0) raw_q[start].restart = 1'b1;
	endfunction

	task automatic write_reg(input logic [PADDR_W-3:0] idx, input logic [PDATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		decode_chk.set_limit(val);
	endtask

	// Offer every queued beat, idling at random in between, then hold the
	// sender back until the last body beat owed has come out.
	task automatic play_and_settle();
		raw_beat_t b;
		while (raw_q.size() != 0) begin
			b = raw_q.pop_front();
			while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
				raw_if.valid <= 1'b0;
				@(posedge clk);
			end
			raw_if.valid   <= 1'b1;
			raw_if.in_byte <= b.ch;
			raw_if.restart <= b.restart;
			raw_if.closed  <= b.closed;
			do @(posedge clk); while (raw_if.ready !== 1'b1);
		end
		raw_if.valid <= 1'b0;
		@(posedge clk);
		while (decode_chk.pending() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input logic [PDATA_W-1:0] limit_val, input int beats,
			input int widest);
		write_reg(REG_BODY_LIMIT, limit_val);
		while (raw_q.size() < beats) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8)) begin
					put(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
						$urandom_range(0, 15) == 0);
				end
			end else begin
				build_body(widest);
			end
		end
		play_and_settle();
	endtask

	initial begin
		arst_n         <= 1'b0;
		raw_if.valid   <= 1'b0;
		raw_if.in_byte <= '0;
		raw_if.restart <= 1'b0;
		raw_if.closed  <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed body under the reset limit. Leading blanks including a lone
		// LF, a sign and a 0x prefix; a lone CR ends the digits and junk
		// follows before the real line end.
		put(" ", 1'b1);
		put(CHAR_LF);
		put("+");
		put_text("0x2");
		put(CHAR_CR);
		put("G");
		put(CHAR_CR);
		put(CHAR_LF);
		// Data bytes at both extremes.
		put(8'h00);
		put(8'hFF);
		// CR then a hex digit: the held CR opens the next size line, and nine
		// digits saturate the size, which then trips the limit.
		put(CHAR_CR);
		put_text("fffffffff");
		put(CHAR_CR);
		put(CHAR_LF);
		// Stopped: a byte and a close are ignored and the status holds.
		put("7");
		put(8'h00, 1'b0, 1'b1);
		// Restart and close in one beat.
		put(8'h00, 1'b1, 1'b1);
		// Negative size, its digits cut short by a NUL.
		put("-", 1'b1);
		put(8'h00);
		put(CHAR_CR);
		put(CHAR_LF);
		// Prefix with no digit after it reads as zero.
		put("0", 1'b1);
		put("x");
		put(CHAR_CR);
		put(CHAR_LF);
		play_and_settle();

		// Widest limit: saturated sizes still fit when nothing has gone out yet.
		run_phase(32'hFFFF_FFFF, 85, 12);

		// Zero limit, with neither side idling for the whole phase.
		idle_on = 1'b0;
		run_phase(32'h0000_0000, 40, 12);
		idle_on = 1'b1;

		// Tight limit while the receiver holds off and the block backs up.
		hold_req = 1'b1;
		run_phase(32'($urandom_range(16, 96)), 100, 12);

		// Arbitrary limit and longer chunks.
		run_phase($urandom, 125, 40);

		repeat (8) @(posedge clk);
		decode_chk.close_out();
		if (decode_chk.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_if.sv
hw/rtl/hcbd_cfg.sv
hw/rtl/hcbd_step.sv
hw/rtl/http_chunked_body_decoder.sv
tb/tb_http_chunked_body_decoder.sv
